// File: src/modular_exponentiation_macros.svh
// ----------------------------------------------------------------------------
// Modular exponentiation assertion macros
// Shared concurrent assertion forms, clocked on aclk, off during reset.
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

// same-cycle implication
`define MEXP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MEXP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/mexp_pkg.sv
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Widths, register map and the request/response types of the shared
// multiply-reduce unit.
// ----------------------------------------------------------------------------
package mexp_pkg;

    localparam int MOD_BITS             = 31;
    localparam int PROD_BITS            = 2 * MOD_BITS;
    localparam int RED_STEPS            = PROD_BITS / 2;
    localparam int RED_CNT_BITS         = $clog2(RED_STEPS);
    localparam int OPERAND_BITS_DEFAULT = 31;

    localparam int S_TDATA_BITS = 64;
    localparam int M_TDATA_BITS = 32;

    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    localparam logic REG_MODULUS = 1'b0;

    typedef struct packed {
        logic                start;
        logic [MOD_BITS-1:0] op_a;
        logic [MOD_BITS-1:0] op_b;
        logic [MOD_BITS-1:0] modulus;
    } mexp_mul_req_t;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [MOD_BITS-1:0] value;
    } mexp_mul_rsp_t;

endpackage

// File: src/mexp_mulmod.sv
// ----------------------------------------------------------------------------
// Modular multiply unit
// One registered 31x31 product, then a restoring reduction that retires two
// product bits per cycle against the modulus.
// ----------------------------------------------------------------------------
module mexp_mulmod (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  mexp_pkg::mexp_mul_req_t req,
    output mexp_pkg::mexp_mul_rsp_t rsp
);
    import mexp_pkg::*;

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [RED_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [PROD_BITS-1:0]    prod_reg, prod_next;
    logic [MOD_BITS-1:0]     rem_reg, rem_next;

    logic [MOD_BITS:0]   r1, r2, n_ext;
    logic [MOD_BITS-1:0] s1, s2;

    always_comb begin
        n_ext = {1'b0, req.modulus};
        r1    = {rem_reg, prod_reg[PROD_BITS-1]};
        s1    = (r1 >= n_ext) ? MOD_BITS'(r1 - n_ext) : r1[MOD_BITS-1:0];
        r2    = {s1, prod_reg[PROD_BITS-2]};
        s2    = (r2 >= n_ext) ? MOD_BITS'(r2 - n_ext) : r2[MOD_BITS-1:0];
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        prod_next = prod_reg;
        rem_next  = rem_reg;
        if (req.start && !busy_reg) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            prod_next = PROD_BITS'(req.op_a) * PROD_BITS'(req.op_b);
            rem_next  = '0;
        end else if (busy_reg) begin
            rem_next  = s2;
            prod_next = prod_reg << 2;
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == RED_CNT_BITS'(RED_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
    end

    assign rsp.busy  = busy_reg;
    assign rsp.done  = done_reg;
    assign rsp.value = rem_reg;

endmodule

// File: src/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// Modular exponentiation
// Returns base_value ** exponent mod modulus by right-to-left square-and-
// multiply. Input words on s_* (base, exponent), result words on m_*; the
// modulus is written over the APB port; the user must write it only while the
// block is idle, as the block itself does not enforce this.
// Every multiply and square runs on the shared multiply-reduce unit: a start
// that registers the product, a reduction of all 62 product bits at two bits
// per step, and a done that may start the next multiply.
// s_tready is high only while no item is in work.
// Reset clears the sequencer and the output valid flag and sets the modulus to 1.
// A finished result waits in the output register while m_tready is low; a
// new item may be taken meanwhile and finishes once that register is free.
// ----------------------------------------------------------------------------
`include "modular_exponentiation_macros.svh"

module modular_exponentiation #(
    parameter int OPERAND_BITS = mexp_pkg::OPERAND_BITS_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // s_tdata: base_value[30:0], exponent[61:31], zero[63:62]
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [mexp_pkg::S_TDATA_BITS-1:0]  s_tdata,
    // m_tdata: power_result[30:0], zero[31]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [mexp_pkg::M_TDATA_BITS-1:0]  m_tdata,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [mexp_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [mexp_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [mexp_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                               pready
);
    import mexp_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_SQR   = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    localparam logic [MOD_BITS-1:0] OPERAND_MASK = MOD_BITS'((64'd1 << OPERAND_BITS) - 64'd1);
    localparam logic [MOD_BITS-1:0] ONE          = MOD_BITS'(1);

    logic [2:0]              state_reg, state_next;
    logic [MOD_BITS-1:0]     acc_reg, acc_next;
    logic [MOD_BITS-1:0]     base_reg, base_next;
    logic [OPERAND_BITS-1:0] exp_reg, exp_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [MOD_BITS-1:0]     m_data_reg, m_data_next;
    logic [MOD_BITS-1:0]     modulus_reg;

    logic [MOD_BITS-1:0] n_eff;
    logic                s_accept;
    logic                out_free;
    mexp_mul_req_t       mul_req;
    mexp_mul_rsp_t       mul_rsp;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MODULUS) ? APB_DATA_BITS'(modulus_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg <= ONE;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_MODULUS) begin
            modulus_reg <= pwdata[MOD_BITS-1:0];
        end
    end

    assign n_eff    = (modulus_reg == '0) ? ONE : modulus_reg;
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next    = state_reg;
        acc_next      = acc_reg;
        base_next     = base_reg;
        exp_next      = exp_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_data_next   = m_data_reg;
        mul_req.start   = 1'b0;
        mul_req.op_a    = base_reg;
        mul_req.op_b    = base_reg;
        mul_req.modulus = n_eff;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    acc_next   = ONE;
                    base_next  = s_tdata[MOD_BITS-1:0] & OPERAND_MASK;
                    exp_next   = s_tdata[MOD_BITS +: OPERAND_BITS];
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (exp_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    mul_req.start = 1'b1;
                    if (exp_reg[0]) begin
                        mul_req.op_a = acc_reg;
                        state_next   = ST_MUL;
                    end else begin
                        state_next   = ST_SQR;
                    end
                end
            end
            ST_MUL: begin
                if (mul_rsp.done) begin
                    acc_next = mul_rsp.value;
                    if ((exp_reg >> 1) == '0) begin
                        exp_next   = '0;
                        state_next = ST_DONE;
                    end else begin
                        mul_req.start = 1'b1;
                        state_next    = ST_SQR;
                    end
                end
            end
            ST_SQR: begin
                if (mul_rsp.done) begin
                    base_next  = mul_rsp.value;
                    exp_next   = exp_reg >> 1;
                    state_next = ST_CHECK;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_data_next   = acc_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        acc_reg    <= acc_next;
        base_reg   <= base_next;
        exp_reg    <= exp_next;
        m_data_reg <= m_data_next;
    end

    mexp_mulmod u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_BITS'(m_data_reg);

    `MEXP_ASSERT_NOW(a_busy_blocks_input, mul_rsp.busy, !s_tready, "input taken while unit busy")
    `MEXP_ASSERT_NOW(a_start_when_free, mul_req.start, !mul_rsp.busy, "unit started while busy")
    `MEXP_ASSERT_NOW(a_reduced_value, mul_rsp.done, mul_rsp.value < n_eff, "unreduced product")
    `MEXP_ASSERT_NEXT(a_done_publishes, state_reg == ST_DONE && out_free, m_tvalid && s_tready, "result not published")

endmodule
